[src/assert_macros.svh]
// Concurrent assertion helpers, clocked on i_clk, off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPLIES(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed: implication");

// Next-cycle implication.
`define AST_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

// Condition never holds.
`define AST_NEVER(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition");

`endif

[src/ptw_pkg.sv]
package ptw_pkg;

    localparam int TABLE_PAGES    = 64;
    localparam int WORDS_PER_PAGE = 512;
    localparam int STORE_WORDS    = TABLE_PAGES * WORDS_PER_PAGE;
    localparam int ADDR_W         = $clog2(STORE_WORDS);
    localparam int PPN_W          = 44;
    localparam int PTE_W          = 64;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PPN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PPN = 1'b1;

    localparam logic FUNC_WRITE     = 1'b0;
    localparam logic FUNC_TRANSLATE = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ADDR_HI  = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_NOT_USER = 3'd3;
    localparam logic [2:0] ST_WINDOW   = 3'd4;

    localparam logic [1:0] LVL_TOP = 2'd2;
    localparam logic [1:0] LVL_MID = 2'd1;
    localparam logic [1:0] LVL_BOT = 2'd0;

    typedef struct packed {
        logic        func;
        logic [14:0] entry_index;
        logic [63:0] entry_data;
        logic [63:0] virt_addr;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [55:0] phys_addr;
        logic [1:0]  leaf_level;
        logic [9:0]  leaf_flags;
    } t_out_item;

    typedef enum logic [1:0] {
        PTW_CLEAR,
        PTW_IDLE,
        PTW_START,
        PTW_WAIT
    } t_ptw_state;

    typedef struct packed {
        logic load_item;
        logic clr_step;
        logic issue;
        logic emit;
        logic in_walk;
    } t_ptw_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
        logic clr_last;
    } t_ptw_status;

endpackage

[src/ptw_ram.sv]
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/ptw_dp.sv]
module ptw_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ptw_pkg::t_ptw_cmd                i_cmd,
    output ptw_pkg::t_ptw_status             o_status,
    input  ptw_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ptw_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ptw_pkg::PPN_W-1:0]        i_cfg_data
);
    import ptw_pkg::*;

    logic [PPN_W-1:0]  r_root;
    logic [PPN_W-1:0]  r_base;
    t_in_item          r_item;
    logic [1:0]        r_level;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [PTE_W-1:0]  w_pte;
    logic [PPN_W-1:0]  w_page;
    logic [1:0]        w_lvl_sel;
    logic [8:0]        w_vpn;
    logic [PPN_W:0]    w_diff;
    logic              w_win_ok;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_idx_ok;
    logic              w_va_high;
    logic              w_leaf;
    logic              w_done;
    logic              w_out_free;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [PTE_W-1:0]  w_wdata;
    t_out_item         w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
            r_base <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROOT_PPN: r_root <= i_cfg_data;
                CFG_BASE_PPN: r_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next table page: root at the start, else the PPN of the entry just read
    assign w_page    = i_cmd.in_walk ? w_pte[53:10] : r_root;
    assign w_lvl_sel = i_cmd.in_walk ? (r_level - 2'd1) : LVL_TOP;

    always_comb begin
        case (w_lvl_sel)
            LVL_TOP: w_vpn = r_item.virt_addr[38:30];
            LVL_MID: w_vpn = r_item.virt_addr[29:21];
            LVL_BOT: w_vpn = r_item.virt_addr[20:12];
            default: w_vpn = '0;
        endcase
    end

    assign w_diff    = {1'b0, w_page} - {1'b0, r_base};
    assign w_win_ok  = !w_diff[PPN_W] && (w_diff[PPN_W-1:0] < PPN_W'(TABLE_PAGES));
    assign w_raddr   = ADDR_W'({w_diff[PPN_W-1:0], w_vpn});
    assign w_idx_ok  = 32'(r_item.entry_index) < 32'(STORE_WORDS);
    assign w_va_high = r_item.virt_addr[63:38] != '0;
    assign w_leaf    = (r_level == LVL_BOT) || (w_pte[3:1] != 3'b000);

    always_comb begin
        w_res = '0;
        if (!i_cmd.in_walk) begin
            w_done = (r_item.func == FUNC_WRITE) || w_va_high || !w_win_ok;
            if (r_item.func == FUNC_WRITE) begin
                w_res.status = w_idx_ok ? ST_OK : ST_WINDOW;
            end else if (w_va_high) begin
                w_res.status     = ST_ADDR_HI;
                w_res.leaf_level = LVL_TOP;
            end else begin
                w_res.status     = ST_WINDOW;
                w_res.leaf_level = LVL_TOP;
            end
        end else begin
            w_done = !w_pte[0] || w_leaf || !w_win_ok;
            if (!w_pte[0]) begin
                w_res.status     = ST_INVALID;
                w_res.leaf_level = r_level;
                w_res.leaf_flags = w_pte[9:0];
            end else if (w_leaf) begin
                w_res.leaf_level = r_level;
                w_res.leaf_flags = w_pte[9:0];
                if (w_pte[4]) begin
                    w_res.status    = ST_OK;
                    w_res.phys_addr = {w_pte[53:10], 12'h000};
                end else begin
                    w_res.status = ST_NOT_USER;
                end
            end else begin
                w_res.status     = ST_WINDOW;
                w_res.leaf_level = w_lvl_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.issue) begin
            r_level <= w_lvl_sel;
        end
        if (i_cmd.emit) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_we = i_cmd.clr_step ||
                  (i_cmd.emit && !i_cmd.in_walk && (r_item.func == FUNC_WRITE) && w_idx_ok);
    assign w_waddr = i_cmd.clr_step ? r_clr_cnt : ADDR_W'(r_item.entry_index);
    assign w_wdata = i_cmd.clr_step ? '0 : r_item.entry_data;

    ptw_ram #(
        .WIDTH (PTE_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.issue),
        .i_raddr (w_raddr),
        .o_rdata (w_pte)
    );

    assign o_status.done     = w_done;
    assign o_status.out_free = w_out_free;
    assign o_status.clr_last = r_clr_cnt == ADDR_W'(STORE_WORDS - 1);

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[src/ptw_ctrl.sv]
module ptw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ptw_pkg::t_ptw_status  i_status,
    output ptw_pkg::t_ptw_cmd     o_cmd,
    output ptw_pkg::t_ptw_state   o_state
);
    import ptw_pkg::*;

    t_ptw_state r_state;
    t_ptw_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PTW_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            PTW_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = PTW_IDLE;
                end
            end
            PTW_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = PTW_START;
                end
            end
            PTW_START, PTW_WAIT: begin
                o_cmd.in_walk = (r_state == PTW_WAIT);
                if (i_status.done) begin
                    // hold here (store read data held) until the output slot frees
                    if (i_status.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = PTW_IDLE;
                    end
                end else begin
                    o_cmd.issue = 1'b1;
                    n_state     = PTW_WAIT;
                end
            end
            default: begin
                n_state = PTW_CLEAR;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

[src/sv39_page_table_walker.sv]
// channel  | direction | handshake              | payload
// in       | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
// out      | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item at a time. A write goes from the item register straight to the result
// register; a translate also waits, per walk level, on the registered
// read of the table store.
// After reset a clearing pass zeroes all STORE_WORDS (32768) words of the store;
// no input transfer is taken then, config writes are.
// A stalled output holds the walk; the next item is taken while a result waits.
module sv39_page_table_walker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ptw_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ptw_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptw_pkg::PPN_W-1:0]     i_cfg_data
);
    import ptw_pkg::*;

`include "assert_macros.svh"

    t_ptw_cmd    w_cmd;
    t_ptw_status w_status;
    t_ptw_state  w_state;

    ptw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    ptw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    `AST_IMPLIES(a_emit_slot_free, w_cmd.emit, !o_out_valid || !i_out_stall)
    `AST_NEXT(a_accept_starts, i_in_valid && !o_in_stall, w_state == PTW_START)
    `AST_NEVER(a_issue_emit_excl, w_cmd.issue && w_cmd.emit)

endmodule

[verif/sv39_page_table_walker_tb.sv]
`timescale 1ns / 100ps

module sv39_page_table_walker_tb;
    import ptw_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 200;
    localparam int TAIL_CYCLES = 10;

    localparam logic [PPN_W-1:0] PPN_MAX = '1;

    // PTE flag bits
    localparam int PTE_V = 0;
    localparam int PTE_U = 4;
    localparam logic [9:0] FL_V = 10'h001;
    localparam logic [9:0] FL_R = 10'h002;
    localparam logic [9:0] FL_W = 10'h004;
    localparam logic [9:0] FL_X = 10'h008;
    localparam logic [9:0] FL_U = 10'h010;
    localparam logic [9:0] FL_A = 10'h040;
    localparam logic [9:0] FL_D = 10'h080;

    // vpn2 = 1, vpn1 = 2, vpn0 = 3, nonzero page offset
    localparam logic [63:0] DIR_VA = 64'h0000_0000_4040_3ABC;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PPN_W-1:0]     cfg_data  = '0;

    // shadow copy of the walker state
    logic [PTE_W-1:0] shadow_store [STORE_WORDS];
    logic [PPN_W-1:0] root_ppn = '0;
    logic [PPN_W-1:0] base_ppn = '0;

    t_out_item pending_results [$];
    int        err_count  = 0;
    int        items_sent = 0;
    int        out_wait   = 0;
    bit        idle_en    = 1'b1;
    logic      out_hold   = 1'b0;

    sv39_page_table_walker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic bit page_in_window(input logic [PPN_W-1:0] ppn);
        return ppn >= base_ppn && (ppn - base_ppn) < PPN_W'(TABLE_PAGES);
    endfunction

    function automatic logic [ADDR_W-1:0] slot(input int page_off, input logic [63:0] va,
                                               input int lvl);
        return ADDR_W'(page_off * WORDS_PER_PAGE + int'(va[12 + 9 * lvl +: 9]));
    endfunction

    function automatic logic [PTE_W-1:0] make_pte(input logic [PPN_W-1:0] ppn,
                                                  input logic [9:0] flags);
        return {10'h000, ppn, flags};
    endfunction

    // Expected walker response; applies table writes to the shadow store.
    function automatic t_out_item walk_result(input t_in_item item);
        t_out_item        res;
        logic [PTE_W-1:0] pte;
        logic [PPN_W-1:0] page;
        logic [8:0]       vpn;
        int               lvl;
        res = '0;
        if (item.func == FUNC_WRITE) begin
            if (int'(item.entry_index) >= STORE_WORDS) begin
                res.status = ST_WINDOW;
            end else begin
                shadow_store[item.entry_index] = item.entry_data;
            end
            return res;
        end
        if (item.virt_addr[63:38] != '0) begin
            res.status     = ST_ADDR_HI;
            res.leaf_level = LVL_TOP;
            return res;
        end
        page = root_ppn;
        pte  = '0;
        for (lvl = 2; lvl >= 0; lvl--) begin
            res.leaf_level = lvl[1:0];
            if (!page_in_window(page)) begin
                res.status = ST_WINDOW;
                return res;
            end
            vpn = item.virt_addr[12 + 9 * lvl +: 9];
            pte = shadow_store[int'(page - base_ppn) * WORDS_PER_PAGE + int'(vpn)];
            if (!pte[PTE_V]) begin
                res.status     = ST_INVALID;
                res.leaf_flags = pte[9:0];
                return res;
            end
            // level 0 is final no matter what RWX says
            if (lvl == 0 || pte[3:1] != 3'b000) break;
            page = pte[53:10];
        end
        res.leaf_flags = pte[9:0];
        if (!pte[PTE_U]) begin
            res.status = ST_NOT_USER;
            return res;
        end
        res.status    = ST_OK;
        res.phys_addr = {pte[53:10], 12'h000};
        return res;
    endfunction

    task automatic send_item(input t_in_item item);
        int gap;
        gap = idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge i_clk); while (in_stall);
        pending_results.push_back(walk_result(item));
        items_sent++;
    endtask

    task automatic write_word(input logic [ADDR_W-1:0] idx, input logic [PTE_W-1:0] data);
        t_in_item it;
        it.func        = FUNC_WRITE;
        it.entry_index = idx;
        it.entry_data  = data;
        it.virt_addr   = {$urandom, $urandom};
        send_item(it);
    endtask

    task automatic translate(input logic [63:0] va);
        t_in_item it;
        it.func        = FUNC_TRANSLATE;
        it.entry_index = 15'($urandom);
        it.entry_data  = {$urandom, $urandom};
        it.virt_addr   = va;
        send_item(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Only written with the walker empty.
    task automatic set_regs(input logic [PPN_W-1:0] root, input logic [PPN_W-1:0] base);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ROOT_PPN;
        cfg_data  <= root;
        do @(posedge i_clk); while (!cfg_ready);
        root_ppn   = root;
        cfg_index <= CFG_BASE_PPN;
        cfg_data  <= base;
        do @(posedge i_clk); while (!cfg_ready);
        base_ppn   = base;
        cfg_valid <= 1'b0;
    endtask

    task automatic noise_item();
        t_in_item it;
        it.func        = 1'($urandom_range(0, 1));
        it.entry_index = 15'($urandom_range(0, STORE_WORDS - 1));
        it.entry_data  = {$urandom, $urandom};
        it.virt_addr   = {$urandom, $urandom};
        if (it.func == FUNC_TRANSLATE && $urandom_range(0, 3) != 0) it.virt_addr[63:38] = '0;
        send_item(it);
    endtask

    // Build a chain of table entries down to a leaf, with occasional faults, then walk it.
    task automatic random_walk();
        logic [63:0]      va;
        logic [PTE_W-1:0] pte;
        logic [9:0]       flags;
        logic [PPN_W-1:0] next_ppn;
        int               page_off;
        int               next_off;
        int               lim;
        int               lvl;
        int               fault;
        bit               done;
        va = {$urandom, $urandom};
        if ($urandom_range(0, 19) != 0) va[63:38] = '0;
        page_off = int'(root_ppn - base_ppn);
        lim      = (PPN_MAX - base_ppn) < PPN_W'(TABLE_PAGES - 1) ?
                   int'(PPN_MAX - base_ppn) : TABLE_PAGES - 1;
        done     = 1'b0;
        for (lvl = 2; lvl >= 0 && !done; lvl--) begin
            fault    = $urandom_range(0, 19);
            flags    = 10'($urandom);
            next_off = $urandom_range(0, lim);
            next_ppn = base_ppn + PPN_W'(next_off);
            if (lvl == 0 || $urandom_range(0, 2) == 0) begin
                if (lvl > 0 && flags[3:1] == 3'b000) flags[1] = 1'b1;
                flags[PTE_U] = (fault != 2);
                next_ppn     = PPN_W'({$urandom, $urandom});
                done         = 1'b1;
            end else begin
                flags[3:1] = 3'b000;
                if (fault == 1) begin
                    next_ppn = PPN_W'({$urandom, $urandom});
                    done     = 1'b1;
                end
            end
            flags[PTE_V] = (fault != 0);
            if (fault == 0) done = 1'b1;
            pte = {10'($urandom), next_ppn, flags};
            // now and then leave a stale entry in place
            if ($urandom_range(0, 15) != 0) write_word(slot(page_off, va, lvl), pte);
            page_off = next_off;
        end
        translate(va);
        if ($urandom_range(0, 3) == 0) translate({va[63:12], 12'($urandom)});
    endtask

    task automatic stimulus_step();
        if ($urandom_range(0, 15) == 0) idle_en = !idle_en;
        if (page_in_window(root_ppn) && $urandom_range(0, 4) != 0) random_walk();
        else noise_item();
    endtask

    task automatic run_phase(input logic [PPN_W-1:0] root, input logic [PPN_W-1:0] base,
                             input int n_items);
        int start;
        set_regs(root, base);
        start = items_sent;
        while (items_sent - start < n_items) stimulus_step();
    endtask

    task automatic test_directed();
        set_regs(44'd16, 44'd16);
        translate(64'h0000_0040_0000_0000);
        translate(DIR_VA);
        write_word(slot(0, DIR_VA, 2), make_pte(44'd17, FL_V));
        translate(DIR_VA);
        write_word(slot(1, DIR_VA, 1), make_pte(44'd18, FL_V | FL_A));
        translate(DIR_VA);
        write_word(slot(2, DIR_VA, 0),
                   make_pte(44'hABCDE, FL_V | FL_R | FL_W | FL_U | FL_A | FL_D));
        translate(DIR_VA);
        write_word(slot(2, DIR_VA, 0), make_pte(44'h123, FL_V));
        translate(DIR_VA);
        // reserved bits set and RWX clear, still final at level 0
        write_word(slot(2, DIR_VA, 0), {10'h3FF, PPN_MAX, FL_V | FL_U});
        translate(DIR_VA);
        write_word(slot(2, DIR_VA, 0), make_pte(44'h5, 10'h3FE));
        translate(DIR_VA);
        write_word(slot(1, DIR_VA, 1), make_pte(44'h2_0000, FL_V | FL_R | FL_X | FL_U));
        translate(DIR_VA);
        write_word(slot(1, DIR_VA, 1), make_pte(44'h15, FL_V | FL_R));
        translate(DIR_VA);
        // next table just below the window
        write_word(slot(1, DIR_VA, 1), make_pte(44'd15, FL_V));
        translate(DIR_VA);
        // next table just past the window
        write_word(slot(0, DIR_VA, 2), make_pte(44'd80, FL_V));
        translate(DIR_VA);
        write_word(slot(0, DIR_VA, 2), make_pte(44'h3, FL_V | FL_W | FL_U));
        translate(DIR_VA);
        write_word(slot(0, DIR_VA, 2), make_pte(44'h3, FL_V | FL_X));
        translate(DIR_VA);
        write_word(ADDR_W'(STORE_WORDS - 1), '1);
        translate(64'h0000_003F_FFFF_FFFF);
    endtask

    task automatic test_random_phases();
        logic [PPN_W-1:0] base;
        base = PPN_W'($urandom_range(0, 1 << 20));
        run_phase(base + PPN_W'($urandom_range(0, TABLE_PAGES - 1)), base, PHASE_ITEMS);
        run_phase('0, '0, PHASE_ITEMS);
        run_phase(PPN_MAX, PPN_MAX - PPN_W'(TABLE_PAGES - 1), PHASE_ITEMS);
        run_phase(PPN_MAX, PPN_MAX, PHASE_ITEMS);
        // root table outside the window
        run_phase('0, PPN_MAX, 100);
        run_phase(PPN_MAX, '0, 100);
        base = PPN_W'({$urandom, $urandom});
        run_phase(base + PPN_W'($urandom_range(0, TABLE_PAGES - 1)), base, 300);
    endtask

    task automatic test_backpressure();
        int n;
        set_regs(44'd200, 44'd180);
        idle_en = 1'b0;
        fork
            begin
                out_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_hold <= 1'b0;
            end
            begin
                for (n = 0; n < 40; n++) stimulus_step();
            end
        join
        // sender waits for the walker to go empty, then resumes
        drain();
        idle_en = 1'b1;
        for (n = 0; n < 20; n++) stimulus_step();
    endtask

    always @(posedge i_clk) begin : rx
        t_out_item want;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected, got %p", $time, out_item);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_item.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, out_item.status);
                        err_count++;
                    end
                    if (out_item.phys_addr !== want.phys_addr) begin
                        $display("%0t: phys_addr expected %h got %h",
                                 $time, want.phys_addr, out_item.phys_addr);
                        err_count++;
                    end
                    if (out_item.leaf_level !== want.leaf_level) begin
                        $display("%0t: leaf_level expected %0d got %0d",
                                 $time, want.leaf_level, out_item.leaf_level);
                        err_count++;
                    end
                    if (out_item.leaf_flags !== want.leaf_flags) begin
                        $display("%0t: leaf_flags expected %h got %h",
                                 $time, want.leaf_flags, out_item.leaf_flags);
                        err_count++;
                    end
                end
                out_wait = idle_en ? $urandom_range(0, 3) : 0;
            end else if (out_wait > 0) begin
                out_wait--;
            end
        end
        out_stall <= out_hold || (out_wait > 0);
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phases();
        test_backpressure();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sv39_page_table_walker.f]
+incdir+src
src/ptw_pkg.sv
src/ptw_ram.sv
src/ptw_dp.sv
src/ptw_ctrl.sv
src/sv39_page_table_walker.sv
verif/sv39_page_table_walker_tb.sv
